// ===== design/key_hash_bucket_router_macros.svh =====
// Assertion macros shared by the key hash bucket router RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef KEY_HASH_BUCKET_ROUTER_MACROS_SVH
`define KEY_HASH_BUCKET_ROUTER_MACROS_SVH
`ifndef SYNTHESIS
`define KHBR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("khbr assertion failed");
`define KHBR_NEVER(lbl, clk, rstn, expr) \
	`KHBR_ASSERT(lbl, clk, rstn, !(expr))
`else
`define KHBR_ASSERT(lbl, clk, rstn, prop)
`define KHBR_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== design/khbr_pkg.sv =====
// Package for the key hash bucket router: constants, payload and queue entry types.
// No dependencies; imported by every module of the block except khbr_ram.
`timescale 1ns / 1ps

package khbr_pkg;

	localparam int BUCKETS     = 100;
	localparam int MAX_SERVERS = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int BKT_W  = 7;
	localparam int SRV_W  = 4;
	localparam int HASH_W = 32;

	localparam logic [HASH_W-1:0] HASH_START = 32'd1;
	localparam logic [HASH_W-1:0] STEP_START = 32'd4;
	localparam logic [HASH_W-1:0] STEP_INC   = 32'd3;
	localparam int                LOW_BITS   = 6;

	// floor(2^32 / BUCKETS); the quotient estimate is short by at most one
	localparam logic [HASH_W-1:0] HASH_RECIP = 32'((64'd1 << 32) / BUCKETS);

	localparam logic CMD_KEY = 1'b0;
	localparam logic CMD_MAP = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       key_byte;
		logic             last_byte;
		logic [BKT_W-1:0] map_bucket;
		logic [SRV_W-1:0] map_server;
		logic             map_valid;
	} khbr_req_t;

	typedef struct packed {
		logic [BKT_W-1:0]  bucket;
		logic [SRV_W-1:0]  server;
		logic              mapped;
		logic [HASH_W-1:0] hash_value;
	} khbr_rsp_t;

	typedef struct packed {
		logic              is_map;
		logic [HASH_W-1:0] hash;
		logic [BKT_W-1:0]  bkt;
		logic [SRV_W-1:0]  srv;
		logic              vld;
	} khbr_qent_t;

endpackage

// ===== design/khbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module khbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/khbr_front.sv =====
// Front part: accepts request transfers, runs the string hash and queues in-range map
// writes and finished keys. Depends on khbr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "key_hash_bucket_router_macros.svh"

module khbr_front import khbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  khbr_req_t  req,
	output logic       push,
	output khbr_qent_t push_data,
	input  logic       full,
	input  logic       clr_busy
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] step_q;
	logic [HASH_W-1:0] mix_base;
	logic [HASH_W+7:0] mix_prod;
	logic [HASH_W-1:0] hash_nxt;
	logic              acc;
	logic              is_key;
	logic              map_ok;

	assign req_stall = full || clr_busy;
	assign acc       = req_valid && !req_stall;
	assign is_key    = (req.cmd == CMD_KEY);
	assign map_ok    = (int'(req.map_bucket) < BUCKETS) && (int'(req.map_server) < MAX_SERVERS);

	assign mix_base = {{(HASH_W-LOW_BITS){1'b0}}, hash_q[LOW_BITS-1:0]} + step_q;
	assign mix_prod = mix_base * req.key_byte;
	assign hash_nxt = hash_q ^ (mix_prod[HASH_W-1:0] + {hash_q[HASH_W-9:0], 8'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_START;
			step_q <= STEP_START;
		end else if (acc && is_key) begin
			if (req.last_byte) begin
				hash_q <= HASH_START;
				step_q <= STEP_START;
			end else begin
				hash_q <= hash_nxt;
				step_q <= step_q + STEP_INC;
			end
		end
	end

	assign push = acc && (is_key ? req.last_byte : map_ok);

	always_comb begin
		push_data        = '0;
		push_data.is_map = !is_key;
		push_data.hash   = hash_nxt;
		push_data.bkt    = req.map_bucket;
		push_data.vld    = req.map_valid;
		push_data.srv    = req.map_valid ? req.map_server : '0;
	end

	`KHBR_ASSERT(a_hash_restart, clk, arst_n, (acc && is_key && req.last_byte) |=> (hash_q == HASH_START && step_q == STEP_START))
	`KHBR_NEVER(a_push_when_full, clk, arst_n, push && full)
	`KHBR_ASSERT(a_map_keeps_hash, clk, arst_n, (acc && !is_key) |=> $stable(hash_q))

endmodule

// ===== design/khbr_queue.sv =====
// Short queue between the front and back parts of the router.
// Depends on khbr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "key_hash_bucket_router_macros.svh"

module khbr_queue import khbr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  khbr_qent_t push_data,
	input  logic       pop,
	output khbr_qent_t head,
	output logic       full,
	output logic       empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	khbr_qent_t    ent_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`KHBR_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`KHBR_ASSERT(a_cnt_bound, clk, arst_n, int'(cnt_q) <= DEPTH)
	`KHBR_ASSERT(a_ptr_track, clk, arst_n, empty |-> (wr_q == rd_q))

endmodule

// ===== design/khbr_back.sv =====
// Back part: reduces the hash to a bucket, applies map writes and looks up the server.
// Depends on khbr_pkg, khbr_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "key_hash_bucket_router_macros.svh"

module khbr_back import khbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  khbr_qent_t head,
	input  logic       empty,
	output logic       pop,
	output logic       clr_busy,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output khbr_rsp_t  rsp
);

	localparam int AW = $clog2(BUCKETS);
	localparam int RW = $clog2(2 * BUCKETS);
	localparam int MW = SRV_W + 1;

	logic                clr_busy_q;
	logic [AW-1:0]       clr_idx_q;
	logic                adv;
	logic [2*HASH_W-1:0] recip_prod;
	logic [HASH_W-1:0]   back_mul;

	logic                v_s1;
	khbr_qent_t          ent_s1;
	logic [HASH_W-1:0]   quo_s1;
	logic                v_s2;
	khbr_qent_t          ent_s2;
	logic [RW-1:0]       rem_s2;
	logic [RW-1:0]       rem_fix;
	logic [AW-1:0]       bkt_rd;
	logic                v_s4;
	logic [AW-1:0]       bkt_s4;
	logic [HASH_W-1:0]   hash_s4;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [MW-1:0]       ram_wdata;
	logic                ram_re;
	logic [MW-1:0]       ram_rdata;

	assign clr_busy = clr_busy_q;
	assign adv      = !v_s4 || !rsp_stall;
	assign pop      = adv && !empty && !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(BUCKETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign recip_prod = 64'(head.hash) * 64'(HASH_RECIP);
	assign back_mul   = quo_s1 * 32'(BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s4 <= v_s2 && !ent_s2.is_map;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1  <= head;
			quo_s1  <= recip_prod[2*HASH_W-1:HASH_W];
			ent_s2  <= ent_s1;
			rem_s2  <= RW'(ent_s1.hash - back_mul);
			bkt_s4  <= bkt_rd;
			hash_s4 <= ent_s2.hash;
		end
	end

	assign rem_fix = (rem_s2 >= RW'(BUCKETS)) ? rem_s2 - RW'(BUCKETS) : rem_s2;
	assign bkt_rd  = AW'(rem_fix);

	assign ram_we    = clr_busy_q || (adv && v_s2 && ent_s2.is_map);
	assign ram_waddr = clr_busy_q ? clr_idx_q : AW'(ent_s2.bkt);
	assign ram_wdata = clr_busy_q ? '0 : {ent_s2.vld, ent_s2.srv};
	assign ram_re    = adv && v_s2 && !ent_s2.is_map;

	khbr_ram #(
		.WIDTH(MW),
		.DEPTH(BUCKETS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(bkt_rd),
		.rdata(ram_rdata)
	);

	assign rsp_valid       = v_s4;
	assign rsp.bucket      = BKT_W'(bkt_s4);
	assign rsp.server      = ram_rdata[SRV_W-1:0];
	assign rsp.mapped      = ram_rdata[SRV_W];
	assign rsp.hash_value  = hash_s4;

	`KHBR_ASSERT(a_clr_idle, clk, arst_n, clr_busy_q |-> !(v_s1 || v_s2 || v_s4))
	`KHBR_NEVER(a_ram_rw_clash, clk, arst_n, ram_we && ram_re)
	`KHBR_ASSERT(a_bkt_range, clk, arst_n, (v_s2 && !ent_s2.is_map) |-> (int'(rem_fix) < BUCKETS))

endmodule

// ===== design/key_hash_bucket_router.sv =====
// Top level of the key hash bucket router: front hash unit, queue, back lookup unit.
// Depends on khbr_pkg, khbr_front, khbr_queue and khbr_back.
`timescale 1ns / 1ps

// Takes one request transfer per cycle while req_stall is low: a key byte, which is
// folded into a 32-bit string hash by one multiply-add-xor, or a bucket map write.
// On the last byte of a key the hash is queued to the back unit, which reduces it
// modulo the bucket count by a reciprocal multiply and one correction, then reads
// the bucket-to-server map. A taken queue head passes the s1, s2 and s4 registers
// before rsp_valid rises; map writes and lookups stay in request order. Sustained
// rate is one request per cycle while rsp is not stalled; a stalled result holds
// the back unit, and the queue of QUEUE_DEPTH entries takes finished keys and map
// writes until it fills, then req_stall rises. After reset, req_stall is high while
// the map memory is cleared one entry per cycle.

module key_hash_bucket_router import khbr_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  khbr_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output khbr_rsp_t rsp
);

	logic       push;
	khbr_qent_t push_data;
	logic       pop;
	khbr_qent_t head;
	logic       full;
	logic       empty;
	logic       clr_busy;

	khbr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.clr_busy (clr_busy)
	);

	khbr_queue #(
		.DEPTH(QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	khbr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.clr_busy (clr_busy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== sim/tb_key_hash_bucket_router.sv =====
// Self-checking testbench for key_hash_bucket_router: directed and random key/map traffic.
// The scoreboard class predicts each routed key; depends on khbr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_key_hash_bucket_router import khbr_pkg::*;;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1800;

	class route_tracker;
		logic [HASH_W-1:0] hash_acc;
		logic [HASH_W-1:0] step_acc;
		bit                map_used[BUCKETS];
		logic [SRV_W-1:0]  map_srv[BUCKETS];
		khbr_rsp_t         route_q[$];
		int                errors;
		int                routed;
		int                hits;
		int                map_writes;

		function new();
			hash_acc = HASH_START;
			step_acc = STEP_START;
			foreach (map_used[i]) begin
				map_used[i] = 1'b0;
				map_srv[i] = '0;
			end
		endfunction

		function logic [HASH_W-1:0] fold_byte(logic [HASH_W-1:0] h, logic [HASH_W-1:0] s,
			logic [7:0] b);
			logic [HASH_W-1:0] prod;
			prod = ((h & 32'd63) + s) * {24'd0, b};
			return h ^ (prod + (h << 8));
		endfunction

		function void take_request(khbr_req_t r);
			khbr_rsp_t e;
			if (r.cmd == CMD_MAP) begin
				if (r.map_bucket < BUCKETS && r.map_server < MAX_SERVERS) begin
					map_used[r.map_bucket] = r.map_valid;
					map_srv[r.map_bucket] = r.map_valid ? r.map_server : '0;
					map_writes++;
				end
				return;
			end
			hash_acc = fold_byte(hash_acc, step_acc, r.key_byte);
			step_acc = step_acc + STEP_INC;
			if (!r.last_byte)
				return;
			e.hash_value = hash_acc;
			e.bucket = BKT_W'(hash_acc % BUCKETS);
			e.mapped = map_used[e.bucket];
			e.server = e.mapped ? map_srv[e.bucket] : '0;
			route_q = {route_q, e};
			hash_acc = HASH_START;
			step_acc = STEP_START;
		endfunction

		function void cmp_field(string name, logic [HASH_W-1:0] e, logic [HASH_W-1:0] a);
			if (a !== e) begin
				$display("%0t: %s expected %0h got %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_route(khbr_rsp_t a);
			khbr_rsp_t e;
			if (route_q.size() == 0) begin
				$display("%0t: unexpected result, expected none got %0h", $time, a);
				errors++;
				return;
			end
			e = route_q.pop_front();
			routed++;
			if (e.mapped)
				hits++;
			cmp_field("bucket", e.bucket, a.bucket);
			cmp_field("server", e.server, a.server);
			cmp_field("mapped", e.mapped, a.mapped);
			cmp_field("hash_value", e.hash_value, a.hash_value);
		endfunction

		function int pending();
			return route_q.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	khbr_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	khbr_rsp_t rsp;

	route_tracker sb = new();
	bit           no_idle;
	int           useful;
	int           idle_cycles;

	key_hash_bucket_router u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.take_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_route(rsp);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		int n;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	function automatic khbr_req_t mk_key(logic [7:0] b, bit last);
		khbr_req_t r;
		r = khbr_req_t'($urandom);
		r.cmd = CMD_KEY;
		r.key_byte = b;
		r.last_byte = last;
		return r;
	endfunction

	function automatic khbr_req_t mk_map(logic [BKT_W-1:0] bkt, logic [SRV_W-1:0] srv,
		bit vld);
		khbr_req_t r;
		r = khbr_req_t'($urandom);
		r.cmd = CMD_MAP;
		r.map_bucket = bkt;
		r.map_server = srv;
		r.map_valid = vld;
		return r;
	endfunction

	task automatic send_req(input khbr_req_t r);
		int gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (!(r.cmd == CMD_MAP && r.map_bucket >= BUCKETS))
			useful++;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		logic [BKT_W-1:0] bkt;
		int               len;
		int               pick;
		bit               paused;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		no_idle = 1'b0;
		useful = 0;
		idle_cycles = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty map, byte extremes, multi-byte key
		send_req(mk_key(8'h00, 1'b1));
		send_req(mk_key(8'hff, 1'b1));
		send_req(mk_key(8'h61, 1'b0));
		send_req(mk_key(8'h62, 1'b0));
		send_req(mk_key(8'h63, 1'b1));
		// bucket extremes, last flag on a map write, out-of-range buckets
		send_req(mk_map(7'd0, 4'd15, 1'b1));
		send_req(mk_map(7'd99, 4'd0, 1'b1) | khbr_req_t'({1'b0, 8'd0, 1'b1, 12'd0}));
		send_req(mk_map(7'd127, 4'd5, 1'b1));
		send_req(mk_map(7'd100, 4'd9, 1'b1));
		// hit a mapped bucket, then clear it and miss
		bkt = BKT_W'(sb.fold_byte(HASH_START, STEP_START, 8'hff) % BUCKETS);
		send_req(mk_map(bkt, 4'd7, 1'b1));
		send_req(mk_key(8'hff, 1'b1));
		send_req(mk_map(bkt, 4'd3, 1'b0));
		send_req(mk_key(8'hff, 1'b1));
		// map write inside a key leaves the hash alone
		send_req(mk_key(8'h12, 1'b0));
		send_req(mk_map(7'd5, 4'd2, 1'b1));
		send_req(mk_key(8'h34, 1'b1));
		send_req(mk_key(8'h80, 1'b0));
		send_req(mk_key(8'h01, 1'b1));
		drain();

		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			no_idle = (useful / 300) % 3 == 1;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 7))
						0: send_req(mk_key(8'h00, i == len - 1));
						1: send_req(mk_key(8'hff, i == len - 1));
						default: send_req(mk_key(8'($urandom), i == len - 1));
					endcase
				end
			end else if (pick < 90) begin
				send_req(mk_map(BKT_W'($urandom_range(0, BUCKETS - 1)), SRV_W'($urandom),
					$urandom_range(0, 3) != 0));
			end else if (pick < 95) begin
				send_req(mk_map(BKT_W'($urandom_range(BUCKETS, 127)), SRV_W'($urandom),
					$urandom_range(0, 1)));
			end else begin
				send_req(khbr_req_t'($urandom));
			end
			if (!paused && useful >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Routed %0d keys (%0d to a mapped bucket) with %0d map writes applied,",
			sb.routed, sb.hits, sb.map_writes);
		$display("random stalls on both sides, stall-free stretches and one full drain.");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/khbr_pkg.sv
design/khbr_ram.sv
design/khbr_front.sv
design/khbr_queue.sv
design/khbr_back.sv
design/key_hash_bucket_router.sv
sim/tb_key_hash_bucket_router.sv
